/* src/walu_pkg.sv */
// Package for the word ALU: opcode constants and the input queue depth.
// Used by walu_front and walu_back.
`timescale 1ns / 1ps
package walu_pkg;
  localparam logic [4:0] OP_NOT  = 5'd0;
  localparam logic [4:0] OP_AND  = 5'd1;
  localparam logic [4:0] OP_OR   = 5'd2;
  localparam logic [4:0] OP_XOR  = 5'd3;
  localparam logic [4:0] OP_SHL  = 5'd4;
  localparam logic [4:0] OP_SHR  = 5'd5;
  localparam logic [4:0] OP_SAR  = 5'd6;
  localparam logic [4:0] OP_NEG  = 5'd7;
  localparam logic [4:0] OP_ADD  = 5'd8;
  localparam logic [4:0] OP_MUL  = 5'd9;
  localparam logic [4:0] OP_DIV  = 5'd10;
  localparam logic [4:0] OP_MOD  = 5'd11;
  localparam logic [4:0] OP_UDIV = 5'd12;
  localparam logic [4:0] OP_UMOD = 5'd13;
  localparam logic [4:0] OP_EQ   = 5'd14;
  localparam logic [4:0] OP_LT   = 5'd15;
  localparam logic [4:0] OP_ULT  = 5'd16;

  localparam int QUEUE_DEPTH = 2;
endpackage

/* src/walu_front.sv */
// Front part of the word ALU: an input queue that accepts beats for the back part.
// Depends on walu_pkg.
`timescale 1ns / 1ps
module walu_front #(
  parameter int WORD_BITS = 64
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_valid,
  output logic                 in_stall,
  input  logic [4:0]           in_action,
  input  logic [WORD_BITS-1:0] in_a,
  input  logic [WORD_BITS-1:0] in_b,
  output logic                 q_valid,
  input  logic                 q_stall,
  output logic [4:0]           q_action,
  output logic [WORD_BITS-1:0] q_a,
  output logic [WORD_BITS-1:0] q_b
);
  localparam int AW = $clog2(walu_pkg::QUEUE_DEPTH);
  logic [4:0]           act_r [walu_pkg::QUEUE_DEPTH];
  logic [WORD_BITS-1:0] a_r   [walu_pkg::QUEUE_DEPTH];
  logic [WORD_BITS-1:0] b_r   [walu_pkg::QUEUE_DEPTH];
  logic [AW-1:0] wp_r, rp_r;
  logic [AW:0]   cnt_r;
  logic push, pop;

  assign in_stall = (cnt_r == (AW+1)'(walu_pkg::QUEUE_DEPTH)) ? 1'b1 : 1'b0;
  assign push     = in_valid && !in_stall;
  assign q_valid  = cnt_r != '0;
  assign pop      = q_valid && !q_stall;
  assign q_action = act_r[rp_r];
  assign q_a      = a_r[rp_r];
  assign q_b      = b_r[rp_r];

  always_ff @(posedge clk) begin
    if (push) begin
      act_r[wp_r] <= in_action;
      a_r[wp_r]   <= in_a;
      b_r[wp_r]   <= in_b;
    end
    if (!rst_n) begin
      wp_r  <= '0;
      rp_r  <= '0;
      cnt_r <= '0;
    end else begin
      if (push) wp_r <= wp_r + 1'b1;
      if (pop)  rp_r <= rp_r + 1'b1;
      cnt_r <= cnt_r + (AW+1)'(push) - (AW+1)'(pop);
    end
  end
endmodule

/* src/walu_divider.sv */
// Pipelined unsigned divider, one quotient bit per stage.
// Stand-alone; used by walu_back.
`timescale 1ns / 1ps
module walu_divider #(
  parameter int W = 64,
  parameter int TW = 8
) (
  input  logic          clk,
  input  logic          adv,
  input  logic [W-1:0]  num,
  input  logic [W-1:0]  den,
  input  logic [TW-1:0] tag_in,
  output logic [W-1:0]  quo,
  output logic [W-1:0]  rem,
  output logic [TW-1:0] tag_out
);
  logic [W-1:0]  q_r [W+1];
  logic [W-1:0]  r_r [W+1];
  logic [W-1:0]  d_r [W+1];
  logic [TW-1:0] t_r [W+1];

  always_comb begin
    q_r[0] = num;
    r_r[0] = '0;
    d_r[0] = den;
    t_r[0] = tag_in;
  end

  for (genvar i = 0; i < W; i++) begin : g_stage
    logic [W:0] sh, df;
    assign sh = {r_r[i], q_r[i][W-1]};
    assign df = sh - {1'b0, d_r[i]};
    always_ff @(posedge clk) begin
      if (adv) begin
        d_r[i+1] <= d_r[i];
        t_r[i+1] <= t_r[i];
        if (!df[W]) begin
          r_r[i+1] <= df[W-1:0];
          q_r[i+1] <= {q_r[i][W-2:0], 1'b1};
        end else begin
          r_r[i+1] <= sh[W-1:0];
          q_r[i+1] <= {q_r[i][W-2:0], 1'b0};
        end
      end
    end
  end

  assign quo     = q_r[W];
  assign rem     = r_r[W];
  assign tag_out = t_r[W];
endmodule

/* src/walu_back.sv */
// Back part of the word ALU: lock-step pipeline with multiplier and divider.
// Depends on walu_pkg and walu_divider.
`timescale 1ns / 1ps
module walu_back #(
  parameter int WORD_BITS = 64
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 q_valid,
  output logic                 q_stall,
  input  logic [4:0]           q_action,
  input  logic [WORD_BITS-1:0] q_a,
  input  logic [WORD_BITS-1:0] q_b,
  output logic                 out_valid,
  input  logic                 out_stall,
  output logic [WORD_BITS-1:0] out_res
);
  localparam int W  = WORD_BITS;
  localparam int HW = (W + 1) / 2;
  localparam int LAT = W + 1;
  localparam int TW = 1 + 5 + 2 + W;
  localparam int SW = $clog2(W + 1);

  logic adv;
  logic [LAT-1:0] v_r;
  assign adv     = !(out_stall && v_r[LAT-1]);
  assign q_stall = !adv;
  assign out_valid = v_r[LAT-1];

  logic na, nb, bz, oor;
  logic [W-1:0] ma, mb, simple, lsh, rsh;
  logic [SW-1:0] sa;
  logic [W:0] ult_d;
  logic lt;
  assign na  = q_a[W-1];
  assign nb  = q_b[W-1];
  assign ma  = na ? -q_a : q_a;
  assign mb  = nb ? -q_b : q_b;
  assign bz  = q_b == '0;
  assign oor = nb || (q_b >= W'(W));
  assign sa  = SW'(q_b[SW-1:0]);
  assign lsh = q_a << sa;
  assign rsh = q_a >> sa;
  assign ult_d = {1'b0, q_a} - {1'b0, q_b};
  assign lt  = (na != nb) ? na : ult_d[W];

  always_comb begin
    unique case (q_action)
      walu_pkg::OP_NOT: simple = ~q_a;
      walu_pkg::OP_AND: simple = q_a & q_b;
      walu_pkg::OP_OR:  simple = q_a | q_b;
      walu_pkg::OP_XOR: simple = q_a ^ q_b;
      walu_pkg::OP_SHL: simple = oor ? '0 : lsh;
      walu_pkg::OP_SHR: simple = oor ? '0 : rsh;
      walu_pkg::OP_SAR: simple = oor ? {W{na}} : (rsh | ~({W{1'b1}} >> sa) & {W{na}});
      walu_pkg::OP_NEG: simple = -q_a;
      walu_pkg::OP_ADD: simple = q_a + q_b;
      walu_pkg::OP_EQ:  simple = W'(q_a == q_b);
      walu_pkg::OP_LT:  simple = W'(lt);
      walu_pkg::OP_ULT: simple = W'(ult_d[W]);
      default:          simple = '0;
    endcase
  end

  logic sgn, udv;
  assign sgn = (q_action == walu_pkg::OP_DIV) || (q_action == walu_pkg::OP_MOD);
  assign udv = (q_action == walu_pkg::OP_UDIV) || (q_action == walu_pkg::OP_UMOD);

  // tag: bz, action, {na, nb}, simple / dividend
  logic [TW-1:0] tag_in, tag_out;
  assign tag_in = {bz, q_action, na, nb, (sgn || udv) ? q_a : simple};

  logic [W-1:0] quo, rem;
  walu_divider #(.W(W), .TW(TW)) u_div (
    .clk(clk), .adv(adv),
    .num(sgn ? ma : q_a), .den(sgn ? mb : q_b),
    .tag_in(tag_in), .quo(quo), .rem(rem), .tag_out(tag_out)
  );

  // multiply: split into partial products, register, then sum; pad to divider depth
  logic [HW-1:0] al, bl;
  logic [W-HW-1:0] ah, bh;
  logic [2*HW-1:0] p0_r;
  logic [W-HW-1:0] p1_r, p2_r;
  logic [W-1:0] m_r [1:LAT-2];
  assign al = HW'(q_a);
  assign bl = HW'(q_b);
  assign ah = q_a[W-1:HW];
  assign bh = q_b[W-1:HW];
  always_ff @(posedge clk) begin
    if (adv) begin
      p0_r <= al * bl;
      p1_r <= (W-HW)'(ah * bl);
      p2_r <= (W-HW)'(bh * al);
      m_r[1] <= W'(p0_r) + (W'(p1_r + p2_r) << HW);
      for (int i = 2; i < LAT-1; i++) m_r[i] <= m_r[i-1];
    end
  end

  logic [4:0] t_act;
  logic t_bz, t_na, t_nb;
  logic [W-1:0] t_val, div_res;
  assign {t_bz, t_act, t_na, t_nb} = tag_out[TW-1:W];
  assign t_val = tag_out[W-1:0];

  always_comb begin
    unique case (t_act)
      walu_pkg::OP_DIV:  div_res = t_bz ? '0 : ((t_na != t_nb) ? -quo : quo);
      walu_pkg::OP_MOD:  div_res = t_bz ? t_val : (t_na ? -rem : rem);
      walu_pkg::OP_UDIV: div_res = t_bz ? '0 : quo;
      walu_pkg::OP_UMOD: div_res = t_bz ? t_val : rem;
      walu_pkg::OP_MUL:  div_res = m_r[LAT-2];
      default:           div_res = t_val;
    endcase
  end

  logic [W-1:0] res_r;
  always_ff @(posedge clk) begin
    if (adv) res_r <= div_res;
    if (!rst_n) v_r <= '0;
    else if (adv) v_r <= {v_r[LAT-2:0], q_valid};
  end
  assign out_res = res_r;
endmodule

/* src/word_alu_with_safe_division.sv */
// Word ALU with safe division. Every operation, simple or not, runs through one
// lock-step pipeline set by the divider (one quotient bit per stage); one beat
// enters per cycle unless out_stall holds the pipeline. A result passes through
// the input queue, WORD_BITS divider stages and one output register.
// A two-entry input queue takes beats while the pipeline is held by out_stall.
// Results come in order.
`timescale 1ns / 1ps
module word_alu_with_safe_division #(
  parameter int WORD_BITS = 64
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_stall,
  input  logic [4:0]         in_action,
  input  logic signed [63:0] in_operand_a,
  input  logic signed [63:0] in_operand_b,
  output logic               out_valid,
  input  logic               out_stall,
  output logic signed [63:0] out_result_word
);
  logic q_valid, q_stall;
  logic [4:0] q_action;
  logic [WORD_BITS-1:0] q_a, q_b, res;

  walu_front #(.WORD_BITS(WORD_BITS)) u_front (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_stall(in_stall), .in_action(in_action),
    .in_a(in_operand_a[WORD_BITS-1:0]), .in_b(in_operand_b[WORD_BITS-1:0]),
    .q_valid(q_valid), .q_stall(q_stall), .q_action(q_action), .q_a(q_a), .q_b(q_b)
  );

  walu_back #(.WORD_BITS(WORD_BITS)) u_back (
    .clk(clk), .rst_n(rst_n),
    .q_valid(q_valid), .q_stall(q_stall), .q_action(q_action), .q_a(q_a), .q_b(q_b),
    .out_valid(out_valid), .out_stall(out_stall), .out_res(res)
  );

  assign out_result_word = 64'(signed'(res));
endmodule
